// File: hdl/point_list_range_compressor_core_assert.svh
// assertion macros shared by the rtl files
`ifndef POINT_LIST_RANGE_COMPRESSOR_CORE_ASSERT_SVH
`define POINT_LIST_RANGE_COMPRESSOR_CORE_ASSERT_SVH

// same-cycle implication
`define PLRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plrc assertion failed");

// next-cycle implication
`define PLRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plrc assertion failed");

`endif

// File: hdl/plrc_pkg.sv
`default_nettype none
package plrc_pkg;

    localparam int unsigned PLRC_MAX_BYTES = 5;
    localparam int unsigned PLRC_CNT_W     = 3;

    localparam logic [7:0] PLRC_LETTER_BASE = 8'h61;
    localparam logic [7:0] PLRC_CH_COLON    = 8'h3A;
    localparam logic [7:0] PLRC_CH_CLOSE    = 8'h5D;
    localparam logic [7:0] PLRC_CH_OPEN     = 8'h5B;

    typedef struct packed {
        logic [4:0] point_index;
        logic       list_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_item;
    } t_out_item;

    typedef struct packed {
        logic [PLRC_CNT_W-1:0]               count;
        logic [PLRC_MAX_BYTES-1:0][7:0]      bytes;
    } t_enc_res;

    function automatic logic [7:0] plrc_letter(input logic [4:0] pt);
        return PLRC_LETTER_BASE + {3'b000, pt};
    endfunction

endpackage
`default_nettype wire

// File: hdl/plrc_encode.sv
`default_nettype none
module plrc_encode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire plrc_pkg::t_in_item i_item,
    input  wire logic              i_take,
    output plrc_pkg::t_enc_res     o_res
);
    import plrc_pkg::*;

    logic       r_started;
    logic [4:0] r_prev;
    logic       r_run;

    logic       n_started;
    logic [4:0] n_prev;
    logic       n_run;

    logic       succ;
    logic       run_after;

    assign succ = ({1'b0, i_item.point_index} == ({1'b0, r_prev} + 6'd1));

    always_comb begin
        o_res.count = '0;
        o_res.bytes = '0;
        run_after   = 1'b0;
        if (!r_started) begin
            o_res.bytes[0] = plrc_letter(i_item.point_index);
            o_res.count    = PLRC_CNT_W'(1);
        end else if (!succ) begin
            if (r_run) begin
                o_res.bytes[0] = PLRC_CH_COLON;
                o_res.bytes[1] = plrc_letter(r_prev);
                o_res.bytes[2] = PLRC_CH_CLOSE;
                o_res.bytes[3] = PLRC_CH_OPEN;
                o_res.bytes[4] = plrc_letter(i_item.point_index);
                o_res.count    = PLRC_CNT_W'(5);
            end else begin
                o_res.bytes[0] = PLRC_CH_CLOSE;
                o_res.bytes[1] = PLRC_CH_OPEN;
                o_res.bytes[2] = plrc_letter(i_item.point_index);
                o_res.count    = PLRC_CNT_W'(3);
            end
        end else begin
            run_after = 1'b1;
            // run flush on the final entry
            if (i_item.list_end) begin
                o_res.bytes[0] = PLRC_CH_COLON;
                o_res.bytes[1] = plrc_letter(i_item.point_index);
                o_res.count    = PLRC_CNT_W'(2);
            end
        end
    end

    always_comb begin
        if (i_item.list_end) begin
            n_started = 1'b0;
            n_prev    = '0;
            n_run     = 1'b0;
        end else begin
            n_started = 1'b1;
            n_prev    = i_item.point_index;
            n_run     = run_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_prev    <= '0;
            r_run     <= 1'b0;
        end else if (i_take) begin
            r_started <= n_started;
            r_prev    <= n_prev;
            r_run     <= n_run;
        end
    end

endmodule
`default_nettype wire

// File: hdl/plrc_serial.sv
`default_nettype none
`include "point_list_range_compressor_core_assert.svh"
module plrc_serial (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire plrc_pkg::t_enc_res i_res,
    output logic                    o_free,
    output logic                    o_out_valid,
    output plrc_pkg::t_out_item     o_out_data,
    input  wire logic               i_out_stall
);
    import plrc_pkg::*;

    logic                               r_vld;
    logic [PLRC_CNT_W-1:0]              r_idx;
    logic [PLRC_CNT_W-1:0]              r_cnt;
    logic [PLRC_MAX_BYTES-1:0][7:0]     r_bytes;
    logic                               last;

    assign last   = (r_idx == (r_cnt - PLRC_CNT_W'(1)));
    assign o_free = !r_vld || (last && !i_out_stall);

    assign o_out_valid             = r_vld;
    assign o_out_data.text_byte    = r_bytes[r_idx];
    assign o_out_data.last_of_item = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && !i_out_stall) begin
            if (last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + PLRC_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt   <= i_res.count;
            r_bytes <= i_res.bytes;
        end
    end

    `PLRC_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_vld, r_idx < r_cnt)
    `PLRC_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_load, o_free && i_res.count != '0)
    `PLRC_ASSERT_NEXT(a_stall_holds_idx, i_clk, i_rst_n, r_vld && i_out_stall, r_vld && $stable(r_idx))

endmodule
`default_nettype wire

// File: hdl/point_list_range_compressor_core.sv
// point list range compressor: takes one point index per transfer (list_end
// on the final entry) and sends the compressed list text one byte per
// transfer, with last_of_item on the final byte an entry causes. A new entry
// is taken every cycle while entries yield at most one byte and the output
// does not stall; an entry that yields more bytes (up to five) holds the next
// one until its last byte leaves the single byte-wide output buffer, and one
// that yields none skips it. A first byte is offered the cycle after its take.
`default_nettype none
module point_list_range_compressor_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire plrc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output plrc_pkg::t_out_item      o_out_data
);
    import plrc_pkg::*;

    logic     r_in_vld;
    t_in_item r_in;
    logic     n_in_vld;

    t_enc_res enc_res;
    logic     buf_free;
    logic     take;
    logic     load;
    logic     accept;

    assign take       = r_in_vld && ((enc_res.count == '0) || buf_free);
    assign load       = take && (enc_res.count != '0);
    assign o_in_stall = r_in_vld && !take;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_vld   = accept || (r_in_vld && !take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    plrc_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_take  (take),
        .o_res   (enc_res)
    );

    plrc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_res       (enc_res),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
